// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/wolfpm_pkg.sv
// ----------------------------------------------------------------------------
// wolfpm_pkg
// Shared constants and types of the wake-on-LAN frame pattern matcher.
// ----------------------------------------------------------------------------
package wolfpm_pkg;

    // Pattern store geometry
    localparam int PATTERN_COUNT = 7;
    localparam int PATTERN_BYTES = 128;
    localparam int ADDR_W        = $clog2(PATTERN_BYTES);
    localparam int ENTRY_W       = 9;
    localparam int MASK_BIT      = 8;

    // Field widths
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 7;
    localparam int POS_W    = 8;
    localparam int CFG_W    = 49;
    localparam int CFG_IDX_W = 2;

    // Patterns that can reach a status bit
    localparam int LANES = (PATTERN_COUNT < STATUS_W) ? PATTERN_COUNT : STATUS_W;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Request codes
    typedef logic [1:0] t_req;
    localparam t_req REQ_WRITE = 2'd0;
    localparam t_req REQ_FRAME = 2'd1;
    localparam t_req REQ_READ  = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENABLE  = 2'd0;
    localparam t_cfg_idx CFG_LENGTHS = 2'd1;
    localparam t_cfg_idx CFG_IRQ_EN  = 2'd2;

endpackage

// File: sv/wol_frame_pattern_matcher.sv
// A result passes through the compare stage and the output register after its
// input transaction is accepted. Throughput: one item per cycle unless the
// output stalls; each frame byte reads one entry from every pattern bank in the
// cycle it is accepted, and the compare runs the next cycle.
// Reset: synchronous, active low; clears position, mismatch and status state,
// configuration and the pipeline valids. The pattern store is not cleared.
// ----------------------------------------------------------------------------
// wol_frame_pattern_matcher
// Masked byte pattern matcher for wake-on-LAN frame detection.
// ----------------------------------------------------------------------------
module wol_frame_pattern_matcher
    import wolfpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [2:0]           i_pattern_index,
    input  logic [6:0]           i_byte_index,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_mask_bit,
    input  logic                 i_frame_last,
    // Output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [6:0]           o_match_status,
    output logic                 o_wake_irq,
    output logic                 o_frame_done
);

`include "assert_macros.svh"

    // Configuration registers
    logic [STATUS_W-1:0] r_pattern_en;
    logic [CFG_W-1:0]    r_lengths;
    logic                r_irq_en;

    // Block state
    logic [POS_W-1:0]    r_pos;
    logic [STATUS_W-1:0] r_mismatch;
    logic [STATUS_W-1:0] r_status;

    // Compare stage
    logic                r_s1_valid;
    t_req                r_s1_req;
    logic [7:0]          r_s1_data;
    logic                r_s1_last;
    logic [POS_W-1:0]    r_s1_pos;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_irq;
    logic                r_out_done;

    logic                out_free;
    logic                s1_adv;
    logic                in_acc;
    logic                is_write;
    logic                is_frame;
    logic [POS_W-1:0]    wr_idx;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  w_rdata [PATTERN_COUNT];

    logic [POS_W-1:0]    n_pos;
    logic [STATUS_W-1:0] n_mismatch;
    logic [STATUS_W-1:0] n_status;
    logic [STATUS_W-1:0] shown;
    logic                done;
    logic [POS_W-1:0]    s1_pos_next;
    logic                s1_in_range;

    // Handshake: the compare stage moves on whenever the output register frees
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Decode the accepted transaction
    assign is_frame  = in_acc && (i_req_type == REQ_FRAME);
    assign is_write  = in_acc && (i_req_type == REQ_WRITE)
                       && ({1'b0, i_pattern_index} < 4'(PATTERN_COUNT))
                       && (9'(i_byte_index) < 9'(PATTERN_BYTES));
    assign wr_idx    = POS_W'(i_byte_index);
    assign ram_addr  = (i_req_type == REQ_WRITE) ? wr_idx[ADDR_W-1:0] : r_pos[ADDR_W-1:0];
    assign ram_wdata = {i_mask_bit, i_data_byte};

    // Pattern store: one bank per pattern, all read at the frame position (write address on writes)
    for (genvar p = 0; p < PATTERN_COUNT; p++) begin : g_bank
        logic bank_we;
        assign bank_we = is_write && (i_pattern_index == 3'(p));
        wolfpm_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (PATTERN_BYTES)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (in_acc),
            .i_we    (bank_we),
            .i_addr  (ram_addr),
            .i_wdata (ram_wdata),
            .o_rdata (w_rdata[p])
        );
    end

    // Advance the frame position at accept time
    always_comb begin
        n_pos = r_pos;
        if (is_frame) begin
            if (i_frame_last) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // Compare masked bytes and evaluate matches at frame end; a status read clears the status
    assign s1_pos_next = (r_s1_pos == POS_MAX) ? r_s1_pos : r_s1_pos + POS_W'(1);
    assign s1_in_range = (9'(r_s1_pos) < 9'(PATTERN_BYTES));

    always_comb begin
        n_mismatch = r_mismatch;
        n_status   = r_status;
        done       = 1'b0;
        if (r_s1_req == REQ_FRAME) begin
            for (int p = 0; p < LANES; p++) begin
                if (r_pattern_en[p] && s1_in_range
                    && (POS_W'(r_lengths[p*LEN_W +: LEN_W]) >= r_s1_pos)
                    && w_rdata[p][MASK_BIT]
                    && (w_rdata[p][7:0] != r_s1_data)) begin
                    n_mismatch[p] = 1'b1;
                end
            end
            if (r_s1_last) begin
                for (int p = 0; p < LANES; p++) begin
                    if (r_pattern_en[p] && !n_mismatch[p]
                        && (s1_pos_next > POS_W'(r_lengths[p*LEN_W +: LEN_W]))) begin
                        n_status[p] = 1'b1;
                    end
                end
                n_mismatch = '0;
                done       = 1'b1;
            end
        end
        shown = n_status;
        if (r_s1_req == REQ_READ) begin
            n_status = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_en <= '0;
            r_lengths    <= '0;
            r_irq_en     <= 1'b0;
            r_pos        <= '0;
            r_mismatch   <= '0;
            r_status     <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENABLE:  r_pattern_en <= i_cfg_data[STATUS_W-1:0];
                    CFG_LENGTHS: r_lengths    <= i_cfg_data;
                    CFG_IRQ_EN:  r_irq_en     <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            r_pos <= n_pos;
            if (s1_adv) begin
                r_mismatch <= n_mismatch;
                r_status   <= n_status;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req  <= i_req_type;
            r_s1_data <= i_data_byte;
            r_s1_last <= i_frame_last;
            r_s1_pos  <= r_pos;
        end
        if (s1_adv) begin
            r_out_status <= shown;
            r_out_irq    <= r_irq_en && (n_status != '0);
            r_out_done   <= done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_status = r_out_status;
    assign o_wake_irq     = r_out_irq;
    assign o_frame_done   = r_out_done;

    // Assertions
    `ASSERT_CLK(a_stall_needs_s1, i_clk, i_rst_n, o_in_stall |-> r_s1_valid,
        "input stalled with an empty compare stage")
    `ASSERT_CLK(a_pos_cleared, i_clk, i_rst_n,
        (is_frame && i_frame_last) |=> (r_pos == '0),
        "frame position not cleared after the last byte")
    `ASSERT_CLK(a_mismatch_cleared, i_clk, i_rst_n,
        (s1_adv && (r_s1_req == REQ_FRAME) && r_s1_last) |=> (r_mismatch == '0),
        "mismatch flags not cleared at frame end")
    `ASSERT_CLK(a_irq_needs_status, i_clk, i_rst_n,
        (r_out_valid && o_wake_irq) |-> (o_match_status != '0 || $past(s1_adv)),
        "wake interrupt without status")

endmodule

// File: sv/wolfpm_ram.sv
// ----------------------------------------------------------------------------
// wolfpm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wolfpm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read one entry per enabled cycle and write it when i_we is set; hold read data otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wake-on-LAN frame pattern matcher. A queue of
// pattern writes, frame bytes and status reads feeds a clocked driver; a
// clocked monitor predicts each accepted transaction with a local copy of the
// match state and checks every returned status transaction against it.
// ----------------------------------------------------------------------------
module tb;
    import wolfpm_pkg::*;

    localparam t_req REQ_UNUSED    = 2'd3;
    localparam int   RANDOM_ITEMS  = 750;
    localparam int   PHASE_ITEMS   = 40;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   MAX_REPORTS   = 10;
    localparam int   LIMIT_NS      = 4_000_000;

    typedef struct packed {
        t_req       req;
        logic [2:0] pidx;
        logic [6:0] bidx;
        logic [7:0] data;
        logic       mask;
        logic       last;
    } t_wol_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                irq;
        logic                done;
    } t_wol_rsp;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index = CFG_ENABLE;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_out_stall = 1'b0;
    logic                o_out_valid;
    logic [6:0]          o_match_status;
    logic                o_wake_irq;
    logic                o_frame_done;
    t_wol_req            drv_item    = '0;

    // Transactions waiting for the driver, and status results still owed
    t_wol_req frame_req_q[$];
    t_wol_rsp wake_results_q[$];

    // Handshake bookkeeping between the clocked processes
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;
    int tx_wait   = 0;
    int out_wait  = 0;
    bit tx_burst  = 1'b0;
    bit rx_burst  = 1'b0;
    bit hold_go   = 1'b0;
    bit rx_hold   = 1'b0;

    int fail_count   = 0;
    int result_count = 0;
    int gen_count    = 0;

    // Predicted matcher state
    logic [ENTRY_W-1:0]  bank_q [PATTERN_COUNT][PATTERN_BYTES];
    logic [POS_W-1:0]    pos_q    = '0;
    logic [STATUS_W-1:0] miss_q   = '0;
    logic [STATUS_W-1:0] stat_q   = '0;
    logic [STATUS_W-1:0] cfg_enable  = '0;
    logic [CFG_W-1:0]    cfg_lengths = '0;
    logic                cfg_irq_en  = 1'b0;

    // Stimulus-side view of the store and of the setting about to be used
    logic [ENTRY_W-1:0]  plan_store  [PATTERN_COUNT][PATTERN_BYTES];
    bit                  plan_loaded [PATTERN_COUNT][PATTERN_BYTES];
    logic [STATUS_W-1:0] plan_enable  = '0;
    logic [CFG_W-1:0]    plan_lengths = '0;

    wol_frame_pattern_matcher DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (drv_item.req),
        .i_pattern_index (drv_item.pidx),
        .i_byte_index    (drv_item.bidx),
        .i_data_byte     (drv_item.data),
        .i_mask_bit      (drv_item.mask),
        .i_frame_last    (drv_item.last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_match_status  (o_match_status),
        .o_wake_irq      (o_wake_irq),
        .o_frame_done    (o_frame_done)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic int plan_len(input int p);
        return int'(plan_lengths[p*LEN_W +: LEN_W]);
    endfunction

    // Advance the predicted state by one transaction and return its status
    function automatic t_wol_rsp predict_status(input t_wol_req it);
        t_wol_rsp           r;
        int                 p;
        logic [LEN_W-1:0]   len;
        logic [ENTRY_W-1:0] ent;
        r = '0;
        case (it.req)
            REQ_WRITE: begin
                if (it.pidx < PATTERN_COUNT)
                    bank_q[it.pidx][it.bidx] = {it.mask, it.data};
            end
            REQ_FRAME: begin
                // compare masked bytes of every enabled pattern at this position
                for (p = 0; p < LANES; p++) begin
                    len = cfg_lengths[p*LEN_W +: LEN_W];
                    if (cfg_enable[p] && pos_q <= len && pos_q < PATTERN_BYTES) begin
                        ent = bank_q[p][pos_q[ADDR_W-1:0]];
                        if (ent[MASK_BIT] && ent[7:0] != it.data)
                            miss_q[p] = 1'b1;
                    end
                end
                if (pos_q != POS_MAX)
                    pos_q = pos_q + 1'b1;
                // latch matches of patterns whose whole length was seen
                if (it.last) begin
                    for (p = 0; p < LANES; p++) begin
                        len = cfg_lengths[p*LEN_W +: LEN_W];
                        if (cfg_enable[p] && !miss_q[p] && pos_q > len)
                            stat_q[p] = 1'b1;
                    end
                    pos_q  = '0;
                    miss_q = '0;
                    r.done = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.status = stat_q;
        if (it.req == REQ_READ)
            stat_q = '0;
        r.irq = cfg_irq_en && (stat_q != '0);
        return r;
    endfunction

    // Queue one transaction; ignored ones do not count toward the random total
    task automatic push_req(input t_req rq, input logic [2:0] pi, input logic [6:0] bi,
                            input logic [7:0] d, input logic m, input logic l);
        t_wol_req it;
        it = '{req: rq, pidx: pi, bidx: bi, data: d, mask: m, last: l};
        frame_req_q.push_back(it);
        if (rq == REQ_WRITE && pi < PATTERN_COUNT) begin
            plan_store[pi][bi]  = {m, d};
            plan_loaded[pi][bi] = 1'b1;
        end
        if (!(rq == REQ_UNUSED || (rq == REQ_WRITE && pi >= PATTERN_COUNT)))
            gen_count++;
    endtask

    // Queue one transaction of the given type with random fields
    task automatic push_random(input t_req rq);
        push_req(rq, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endtask

    // Hold until every queued transaction has returned its result
    task automatic wait_idle();
        while (!(frame_req_q.size() == 0 && (!i_in_valid || in_taken) &&
                 wake_results_q.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ENABLE:  cfg_enable  = val[STATUS_W-1:0];
            CFG_LENGTHS: cfg_lengths = val;
            CFG_IRQ_EN:  cfg_irq_en  = val[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load what the new setting will compare, then write all three registers
    task automatic set_config(input logic [STATUS_W-1:0] en, input logic [CFG_W-1:0] lens,
                              input logic irq);
        int p;
        int pos;
        plan_enable  = en;
        plan_lengths = lens;
        for (p = 0; p < PATTERN_COUNT; p++)
            if (en[p])
                for (pos = 0; pos <= plan_len(p); pos++)
                    if (!plan_loaded[p][pos])
                        push_req(REQ_WRITE, 3'(p), 7'(pos), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 3) != 0),
                                 1'($urandom_range(0, 1)));
        write_reg(CFG_ENABLE, CFG_W'(en));
        write_reg(CFG_LENGTHS, lens);
        write_reg(CFG_IRQ_EN, CFG_W'(irq));
    endtask

    function automatic int pick_target();
        int t;
        if (plan_enable == '0)
            return -1;
        t = $urandom_range(0, PATTERN_COUNT - 1);
        while (!plan_enable[t])
            t = $urandom_range(0, PATTERN_COUNT - 1);
        return t;
    endfunction

    // Queue a frame of n bytes shaped after the target pattern, optionally spoiled
    task automatic send_frame(input int n, input int target, input bit spoil);
        int         pos;
        int         bad;
        logic [7:0] d;
        bad = (spoil && target >= 0) ? int'($urandom_range(0, plan_len(target))) : -1;
        for (pos = 0; pos < n; pos++) begin
            d = 8'($urandom_range(0, 255));
            if (target >= 0 && pos < PATTERN_BYTES && plan_store[target][pos][MASK_BIT])
                d = plan_store[target][pos][7:0];
            if (pos == bad)
                d = d ^ 8'($urandom_range(1, 255));
            push_req(REQ_FRAME, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), d,
                     1'($urandom_range(0, 1)), pos == n - 1);
            // drop in an occasional read or pattern write mid-frame
            if (pos != n - 1 && $urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_random(REQ_READ);
                else
                    push_random(REQ_WRITE);
            end
        end
    endtask

    // Input driver: hold a stalled transaction, else wait out the gap and advance
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (tx_wait > 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (frame_req_q.size() > 0) begin
                drv_item   <= frame_req_q.pop_front();
                i_in_valid <= 1'b1;
                tx_wait = draw_gap(tx_burst);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: long hold-off first, then a drawn wait per result
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            out_wait  = draw_gap(rx_burst);
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Receiver hold-off, counted in cycles while the sender keeps offering
    initial begin : rx_hold_off
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Monitor: check the returned transaction, then predict the accepted one
    always @(posedge i_clk) begin : monitor
        t_wol_rsp got;
        t_wol_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                out_taken = 1'b1;
                got = {o_match_status, o_wake_irq, o_frame_done};
                if (wake_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d unexpected: status %h irq %b done %b",
                                 result_count, got.status, got.irq, got.done);
                end else begin
                    want = wake_results_q.pop_front();
                    if (got.status !== want.status || got.irq !== want.irq ||
                        got.done !== want.done) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d mismatch: status exp %h got %h, ",
                                      "irq exp %b got %b, done exp %b got %b"},
                                     result_count, want.status, got.status,
                                     want.irq, got.irq, want.done, got.done);
                    end
                end
                result_count++;
            end
            if (i_in_valid && !o_in_stall) begin
                wake_results_q.push_back(predict_status(drv_item));
                in_taken = 1'b1;
            end
        end
    end

    // Stimulus: reset, directed cases, then random phases of settings
    initial begin : stimulus
        int p;
        int b;
        int phase;
        int phase_end;
        int tgt;
        int lim;
        int k;
        logic [STATUS_W-1:0] en;
        logic [CFG_W-1:0]    lens;
        logic                irq;

        for (p = 0; p < PATTERN_COUNT; p++)
            for (b = 0; b < PATTERN_BYTES; b++) begin
                bank_q[p][b]      = '0;
                plan_store[p][b]  = '0;
                plan_loaded[p][b] = 1'b0;
            end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // status after reset, unused code, out-of-range write, frame with nothing on
        push_req(REQ_READ,   3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        push_req(REQ_UNUSED, 3'd7, 7'd127, 8'hFF, 1'b1, 1'b1);
        push_req(REQ_WRITE,  3'd7, 7'd127, 8'hFF, 1'b1, 1'b1);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'hFF, 1'b0, 1'b1);
        // load pattern 0 (one byte) and pattern 1 (three bytes, middle unmasked)
        push_req(REQ_WRITE,  3'd0, 7'd0,   8'hFF, 1'b1, 1'b0);
        push_req(REQ_WRITE,  3'd1, 7'd0,   8'h00, 1'b1, 1'b0);
        push_req(REQ_WRITE,  3'd1, 7'd1,   8'hA5, 1'b0, 1'b0);
        push_req(REQ_WRITE,  3'd1, 7'd2,   8'h5A, 1'b1, 1'b0);
        push_req(REQ_WRITE,  3'd6, 7'd127, 8'h00, 1'b0, 1'b1);
        set_config(7'h03, CFG_W'(2) << LEN_W, 1'b1);
        // one-byte frame: pattern 0 matches, pattern 1 sees a short frame
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'hFF, 1'b0, 1'b1);
        push_req(REQ_READ,   3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        // pattern 1 matches through its unmasked byte, then mismatches at the end
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h11, 1'b0, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h5A, 1'b0, 1'b1);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h22, 1'b0, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h5B, 1'b0, 1'b1);
        push_req(REQ_READ,   3'd0, 7'd0,   8'h00, 1'b0, 1'b0);
        // change the enable in the middle of a frame
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'hFF, 1'b0, 1'b0);
        set_config(7'h01, CFG_W'(2) << LEN_W, 1'b0);
        push_req(REQ_FRAME,  3'd0, 7'd0,   8'h12, 1'b0, 1'b1);
        push_req(REQ_READ,   3'd0, 7'd0,   8'h00, 1'b0, 1'b0);

        gen_count = 0;
        phase     = 0;
        while (gen_count < RANDOM_ITEMS) begin
            // pick a setting: all on, all off and full lengths come first
            en   = (phase == 0) ? 7'h7F : (phase == 1) ? 7'h00 : 7'($urandom_range(0, 127));
            irq  = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            lens = '0;
            for (p = 0; p < PATTERN_COUNT; p++) begin
                if (phase == 2 || (phase > 2 && $urandom_range(0, 7) == 0))
                    lens[p*LEN_W +: LEN_W] = '1;
                else if (phase != 1)
                    lens[p*LEN_W +: LEN_W] = LEN_W'($urandom_range(0, 9));
            end
            tx_burst = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            set_config(en, lens, irq);
            // hold off the receiver while a frame past the position limit streams in
            if (phase == 0) begin
                hold_go = 1'b1;
                send_frame($urandom_range(256, 280), pick_target(), 1'b0);
            end

            phase_end = gen_count + PHASE_ITEMS;
            while (gen_count < phase_end) begin
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    tgt = pick_target();
                    lim = (tgt >= 0) ? plan_len(tgt) : 0;
                    k   = $urandom_range(0, 99);
                    if (tgt < 0 || k >= 70)
                        send_frame($urandom_range(1, 6), -1, 1'b0);
                    else if (k < 55)
                        send_frame(lim + 1 + $urandom_range(0, 3), tgt,
                                   $urandom_range(0, 4) == 0);
                    else
                        send_frame((lim > 0) ? $urandom_range(1, lim) : 1, tgt, 1'b0);
                end else if (k < 82) begin
                    push_random(REQ_READ);
                end else if (k < 94) begin
                    push_random(REQ_WRITE);
                end else begin
                    push_random(REQ_UNUSED);
                end
            end
            phase++;
        end

        // drain, let the pipeline settle, then report
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && wake_results_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Timeout
    initial begin : watchdog
        #(LIMIT_NS);
        $display("tb failed");
        $finish;
    end

endmodule
